// File: rtl/sdrg_pkg.sv
// Shared types, constants and the epoch-to-bucket function for the
// slow device request gate. No dependencies.
package sdrg_pkg;

   // Ring geometry and pool size
   localparam int WINDOW       = 5;
   localparam int IDX_W        = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int POOL_ENTRIES = 4096;
   localparam int FREE_W       = $clog2(POOL_ENTRIES + 1);
   localparam int FREE_OUT_W   = 13;
   localparam int CNT_W        = 16;
   localparam int EPOCH_W      = 32;
   localparam int SUM_W        = CNT_W + $clog2(WINDOW + 2);

   localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
   localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd5;
   localparam logic [FREE_W-1:0] FREE_FULL   = FREE_W'(POOL_ENTRIES);

   typedef enum logic {
      OP_REQUEST  = 1'b0,
      OP_COMPLETE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      VERDICT_FORWARD    = 3'd0,
      VERDICT_SLOW       = 3'd1,
      VERDICT_POOL_EMPTY = 3'd2,
      VERDICT_REPORTED   = 3'd3,
      VERDICT_DROPPED    = 3'd4
   } verdict_type;

   // 256^k mod WINDOW, evaluated at elaboration only
   function automatic int byte_weight(int k);
      int r;
      r = 1 % WINDOW;
      for (int n = 0; n < k; n++) begin
         r = (r * 256) % WINDOW;
      end
      return r;
   endfunction

   localparam int W1 = byte_weight(1);
   localparam int W2 = byte_weight(2);
   localparam int W3 = byte_weight(3);

   typedef logic [IDX_W-1:0] slot_table_type [256];

   function automatic slot_table_type build_slot_table();
      slot_table_type tbl;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = IDX_W'(i % WINDOW);
      end
      return tbl;
   endfunction

   localparam slot_table_type SLOT_TABLE = build_slot_table();

   // epoch mod WINDOW: fold bytes with their weights, then an 8-bit table
   function automatic logic [IDX_W-1:0] epoch_slot(logic [EPOCH_W-1:0] e);
      logic [13:0] t;
      logic [10:0] u;
      logic [8:0]  v;
      logic [8:0]  w;
      logic [7:0]  x;
      t = 14'(e[7:0]) + 14'(e[15:8]) * 14'(W1) + 14'(e[23:16]) * 14'(W2)
        + 14'(e[31:24]) * 14'(W3);
      u = 11'(t[7:0]) + 11'(t[13:8]) * 11'(W1);
      v = 9'(u[7:0]) + 9'(u[10:8]) * 9'(W1);
      w = 9'(v[7:0]) + 9'(v[8]) * 9'(W1);
      // when w overflows a byte its low byte is small, so this stays in range
      x = w[8] ? (w[7:0] + 8'(W1)) : w[7:0];
      return SLOT_TABLE[x];
   endfunction

endpackage

// File: rtl/sdrg_req_if.sv
// Request channel: one word per request or completion event.
// Depends on sdrg_pkg.
interface sdrg_req_if;
   logic                         valid;
   logic                         ready;
   sdrg_pkg::op_type             operation;
   logic [sdrg_pkg::EPOCH_W-1:0] current_epoch;
   logic [sdrg_pkg::EPOCH_W-1:0] issue_epoch;
   logic                         io_error;

   modport source (output valid, operation, current_epoch, issue_epoch, io_error,
                   input ready);
   modport sink   (input valid, operation, current_epoch, issue_epoch, io_error,
                   output ready);
endinterface

// File: rtl/sdrg_rsp_if.sv
// Result channel: one verdict word per accepted event.
// Depends on sdrg_pkg.
interface sdrg_rsp_if;
   logic                            valid;
   logic                            ready;
   sdrg_pkg::verdict_type           verdict;
   logic [sdrg_pkg::CNT_W-1:0]      timed_out_now;
   logic [sdrg_pkg::FREE_OUT_W-1:0] free_now;

   modport source (output valid, verdict, timed_out_now, free_now, input ready);
   modport sink   (input valid, verdict, timed_out_now, free_now, output ready);
endinterface

// File: rtl/sdrg_csr_if.sv
// Configuration write channel carrying the pending limit word.
// Depends on sdrg_pkg.
interface sdrg_csr_if;
   logic                       valid;
   logic                       ready;
   logic [sdrg_pkg::CNT_W-1:0] pending_limit;

   modport source (output valid, pending_limit, input ready);
   modport sink   (input valid, pending_limit, output ready);
endinterface

// File: rtl/sdrg_slot_calc.sv
// Bucket index calculation for both epochs of an incoming word.
// Depends on sdrg_pkg (epoch_slot).
module sdrg_slot_calc (
   input  logic [sdrg_pkg::EPOCH_W-1:0] current_epoch,
   input  logic [sdrg_pkg::EPOCH_W-1:0] issue_epoch,
   output logic [sdrg_pkg::IDX_W-1:0]   now_slot,
   output logic [sdrg_pkg::IDX_W-1:0]   issue_slot
);

   // epoch modulo ring size for each epoch
   assign now_slot   = sdrg_pkg::epoch_slot(current_epoch);
   assign issue_slot = sdrg_pkg::epoch_slot(issue_epoch);

endmodule

// File: rtl/slow_device_request_gate_core.sv
// Slow device request gate: epoch bucket ring, timed-out total and slot pool.
// Depends on sdrg_pkg, sdrg_req_if, sdrg_rsp_if, sdrg_csr_if, sdrg_slot_calc.
// A request passes through the input register, then the result register.
// Throughput: one word per cycle while the result side accepts; the bucket
// sweep, admission check and counter updates all complete in the single
// stage between the two registers. Reset (synchronous, active high) empties
// the ring, clears the totals, fills the slot pool and sets the limit to 5.
module slow_device_request_gate_core (
   input  logic       clock,
   input  logic       reset,
   sdrg_req_if.sink   req,
   sdrg_rsp_if.source rsp,
   sdrg_csr_if.sink   csr
);

   localparam int W = sdrg_pkg::WINDOW;

   // ---------------------------------------------------------------
   // Signals
   // ---------------------------------------------------------------
   logic [sdrg_pkg::IDX_W-1:0]   now_slot;
   logic [sdrg_pkg::IDX_W-1:0]   issue_slot;

   logic                         s1_valid_ff;
   sdrg_pkg::op_type             s1_op_ff;
   logic [sdrg_pkg::EPOCH_W-1:0] s1_now_ff;
   logic [sdrg_pkg::EPOCH_W-1:0] s1_issued_ff;
   logic                         s1_err_ff;
   logic [sdrg_pkg::IDX_W-1:0]   s1_now_slot_ff;
   logic [sdrg_pkg::IDX_W-1:0]   s1_issue_slot_ff;
   logic                         s1_move;

   logic [sdrg_pkg::CNT_W-1:0]   limit_ff;

   logic [sdrg_pkg::CNT_W-1:0]   count_ff [W];
   logic [sdrg_pkg::CNT_W-1:0]   count_in [W];
   logic [sdrg_pkg::EPOCH_W-1:0] epoch_ff [W];
   logic [sdrg_pkg::EPOCH_W-1:0] epoch_in [W];
   logic [W-1:0]                 valid_ff;
   logic [W-1:0]                 valid_in;
   logic [sdrg_pkg::CNT_W-1:0]   timed_ff;
   logic [sdrg_pkg::CNT_W-1:0]   timed_in;
   logic [sdrg_pkg::FREE_W-1:0]  free_ff;
   logic [sdrg_pkg::FREE_W-1:0]  free_in;
   logic [31:0]                  refused_ff;
   logic [31:0]                  refused_in;

   logic [W-1:0]                 swept;
   logic [sdrg_pkg::CNT_W-1:0]   bucket_base [W];
   logic [sdrg_pkg::SUM_W-1:0]   sweep_sum;
   logic [sdrg_pkg::CNT_W-1:0]   swept_total;
   logic [sdrg_pkg::EPOCH_W-1:0] issue_age;
   sdrg_pkg::verdict_type        verdict;

   logic                         rsp_valid_ff;
   sdrg_pkg::verdict_type        verdict_ff;
   logic [sdrg_pkg::CNT_W-1:0]   timed_out_ff;
   logic [sdrg_pkg::FREE_W-1:0]  free_out_ff;

   // ---------------------------------------------------------------
   // Handshake: input register feeds result register
   // ---------------------------------------------------------------
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_move;
   assign csr.ready = 1'b1;

   // bucket indexes computed ahead of the input register
   sdrg_slot_calc u_slot_calc (
      .current_epoch (req.current_epoch),
      .issue_epoch   (req.issue_epoch),
      .now_slot      (now_slot),
      .issue_slot    (issue_slot)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         s1_op_ff         <= req.operation;
         s1_now_ff        <= req.current_epoch;
         s1_issued_ff     <= req.issue_epoch;
         s1_err_ff        <= req.io_error;
         s1_now_slot_ff   <= now_slot;
         s1_issue_slot_ff <= issue_slot;
      end
   end

   // pending limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sdrg_pkg::LIMIT_RESET;
      end else if (csr.valid && csr.ready) begin
         limit_ff <= csr.pending_limit;
      end
   end

   // ---------------------------------------------------------------
   // Sweep of aged buckets into the timed-out total
   // ---------------------------------------------------------------
   always_comb begin
      sweep_sum = sdrg_pkg::SUM_W'(timed_ff);
      for (int i = 0; i < W; i++) begin
         swept[i]       = valid_ff[i] && ((s1_now_ff - epoch_ff[i]) >= 32'(W));
         bucket_base[i] = swept[i] ? '0 : count_ff[i];
         sweep_sum      = sweep_sum + (swept[i] ? sdrg_pkg::SUM_W'(count_ff[i]) : '0);
      end
      swept_total = (sweep_sum > sdrg_pkg::SUM_W'(sdrg_pkg::CNT_MAX)) ?
                    sdrg_pkg::CNT_MAX : sweep_sum[sdrg_pkg::CNT_W-1:0];
   end

   assign issue_age = s1_now_ff - s1_issued_ff;

   // ---------------------------------------------------------------
   // Next state and verdict
   // ---------------------------------------------------------------
   always_comb begin
      count_in   = count_ff;
      epoch_in   = epoch_ff;
      valid_in   = valid_ff;
      timed_in   = timed_ff;
      free_in    = free_ff;
      refused_in = refused_ff;
      verdict    = sdrg_pkg::VERDICT_FORWARD;
      if (s1_op_ff == sdrg_pkg::OP_REQUEST) begin
         if (free_ff == '0) begin
            // pool empty: nothing changes
            verdict = sdrg_pkg::VERDICT_POOL_EMPTY;
         end else begin
            for (int i = 0; i < W; i++) begin
               if (swept[i]) begin
                  count_in[i] = '0;
                  valid_in[i] = 1'b0;
               end
            end
            timed_in = swept_total;
            if (swept_total > limit_ff) begin
               verdict = sdrg_pkg::VERDICT_SLOW;
               if (refused_ff != '1) begin
                  refused_in = refused_ff + 32'd1;
               end
            end else begin
               // count the request in its bucket
               for (int i = 0; i < W; i++) begin
                  if (sdrg_pkg::IDX_W'(i) == s1_now_slot_ff) begin
                     count_in[i] = (bucket_base[i] != sdrg_pkg::CNT_MAX) ?
                                   bucket_base[i] + 16'd1 : bucket_base[i];
                     epoch_in[i] = s1_now_ff;
                     valid_in[i] = 1'b1;
                  end
               end
               free_in = free_ff - sdrg_pkg::FREE_W'(1);
               verdict = sdrg_pkg::VERDICT_FORWARD;
            end
         end
      end else begin
         // completion: retire from timed-out total or its bucket
         if (issue_age >= 32'(W)) begin
            if (timed_ff != '0) begin
               timed_in = timed_ff - 16'd1;
            end
         end else begin
            for (int i = 0; i < W; i++) begin
               if ((sdrg_pkg::IDX_W'(i) == s1_issue_slot_ff) && (count_ff[i] != '0)) begin
                  count_in[i] = count_ff[i] - 16'd1;
               end
            end
         end
         if (free_ff < sdrg_pkg::FREE_FULL) begin
            free_in = free_ff + sdrg_pkg::FREE_W'(1);
         end
         verdict = s1_err_ff ? sdrg_pkg::VERDICT_DROPPED : sdrg_pkg::VERDICT_REPORTED;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < W; i++) begin
            count_ff[i] <= '0;
         end
         valid_ff   <= '0;
         timed_ff   <= '0;
         free_ff    <= sdrg_pkg::FREE_FULL;
         refused_ff <= '0;
      end else if (s1_move) begin
         count_ff   <= count_in;
         valid_ff   <= valid_in;
         timed_ff   <= timed_in;
         free_ff    <= free_in;
         refused_ff <= refused_in;
      end
   end

   // bucket epochs are only read when the bucket is valid
   always_ff @(posedge clock) begin
      if (s1_move) begin
         epoch_ff <= epoch_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_move) begin
         verdict_ff   <= verdict;
         timed_out_ff <= timed_in;
         free_out_ff  <= free_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.verdict       = verdict_ff;
   assign rsp.timed_out_now = timed_out_ff;
   assign rsp.free_now      = sdrg_pkg::FREE_OUT_W'(free_out_ff);

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= sdrg_pkg::FREE_FULL)
      else $error("free slot count above pool size");

   a_forward_takes_slot: assert property (@(posedge clock) disable iff (reset)
      (s1_move && verdict == sdrg_pkg::VERDICT_FORWARD) |=>
      (free_ff == $past(free_ff) - sdrg_pkg::FREE_W'(1)))
      else $error("forwarded request did not take a slot");

   a_empty_pool_reported: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && verdict_ff == sdrg_pkg::VERDICT_POOL_EMPTY) |-> (free_out_ff == '0))
      else $error("pool empty verdict with free slots");

   a_slow_keeps_pool: assert property (@(posedge clock) disable iff (reset)
      (s1_move && verdict == sdrg_pkg::VERDICT_SLOW) |=> $stable(free_ff))
      else $error("slow refusal changed the slot pool");

endmodule
